[rtl/core/clh_pkg.sv]
`default_nettype none
package clh_pkg;

  localparam int NUM_THREADS_DEF = 16;
  localparam int TID_W = 4;
  localparam int CFG_W = 5;
  localparam int STATUS_W = 3;
  localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

  localparam logic CMD_ENTER = 1'b0;
  localparam logic CMD_EXIT = 1'b1;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_WAITING = 2'd1;
  localparam logic [1:0] MODE_HOLDING = 2'd2;

  localparam logic [STATUS_W-1:0] ST_GRANTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_QUEUED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_ENTER = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_EXIT = 3'd4;

  typedef struct packed {
    logic             command;
    logic [TID_W-1:0] thread_id;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                handoff_valid;
    logic [TID_W-1:0]    handoff_thread;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic fetch;
    logic exec;
    logic scan;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic exit_ok;
    logic scan_done;
  } dp_status_t;

endpackage
`default_nettype wire

[rtl/core/clh_queue_lock_unit.sv]
`default_nettype none
// channel | direction | handshake           | payload
// in      | input     | in_valid/in_ready   | in_data (command, thread_id)
// out     | output    | out_valid/out_ready | out_data (status, handoff_valid, handoff_thread)
// cfg     | input     | cfg_we              | cfg_wdata (active_threads)
//
// enter and rejected requests: the request is latched, its cells are fetched, then the result is registered
// exit: after the exec step the handoff scan visits one thread a cycle while the output register is free
// the next item is accepted in the cycle after the result is loaded
// a stalled output holds the controller until the output register frees up
// synchronous reset restores all cells, thread records and active_threads = 16
module clh_queue_lock_unit #(
  parameter int NUM_THREADS = clh_pkg::NUM_THREADS_DEF
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  clh_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  wire                       out_ready,
  output clh_pkg::out_item_t        out_data,
  input  wire                       cfg_we,
  input  wire [clh_pkg::CFG_W-1:0]  cfg_wdata
);
  import clh_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  clh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  clh_datapath #(
    .NUM_THREADS (NUM_THREADS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .dp_status (dp_status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

[rtl/core/clh_ctrl.sv]
`default_nettype none
module clh_ctrl (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  clh_pkg::dp_status_t     dp_status,
  output clh_pkg::ctrl_cmd_t      cmd
);
  import clh_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_SCAN = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        // hold here while the output register is still occupied
        if (dp_status.out_free) begin
          cmd.exec = 1'b1;
          state_next = dp_status.exit_ok ? S_SCAN : S_IDLE;
        end
      end
      S_SCAN: begin
        if (dp_status.out_free) begin
          cmd.scan = 1'b1;
          if (dp_status.scan_done) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

[rtl/core/clh_datapath.sv]
`default_nettype none
module clh_datapath #(
  parameter int NUM_THREADS = clh_pkg::NUM_THREADS_DEF
) (
  input  wire                         clk,
  input  wire                         rst,
  input  clh_pkg::in_item_t           in_data,
  input  wire                         cfg_we,
  input  wire [clh_pkg::CFG_W-1:0]    cfg_wdata,
  input  clh_pkg::ctrl_cmd_t          cmd,
  output clh_pkg::dp_status_t         dp_status,
  output logic                        out_valid,
  input  wire                         out_ready,
  output clh_pkg::out_item_t          out_data
);
  import clh_pkg::*;

  localparam int THR_W = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
  localparam int CELL_W = $clog2(NUM_THREADS + 1);

  logic [CELL_W-1:0] own_cell [NUM_THREADS];
  logic [CELL_W-1:0] pred_cell [NUM_THREADS];
  logic [1:0]        thread_mode [NUM_THREADS];
  logic              cell_flag [NUM_THREADS+1];
  logic [CELL_W-1:0] tail_cell;
  logic [CFG_W-1:0]  active_threads;

  logic              r_cmd;
  logic [TID_W-1:0]  r_tid;
  logic [CELL_W-1:0] r_own;
  logic [CELL_W-1:0] r_pred;
  logic              r_ok;
  logic [THR_W-1:0]  scan;

  logic [THR_W-1:0]  tidx;
  logic              in_range;
  logic              prev_busy;
  logic              scan_hit;
  logic              scan_last;
  logic              out_free;
  logic              load;
  out_item_t         result;

  assign tidx = THR_W'(r_tid);
  assign in_range = ({1'b0, r_tid} < active_threads) && (32'(r_tid) < NUM_THREADS);
  // flag of the old tail, seen before our own flag is set; an old tail equal to our own cell counts as busy
  assign prev_busy = (tail_cell == r_own) || cell_flag[tail_cell];
  assign scan_hit = (thread_mode[scan] == MODE_WAITING) && (pred_cell[scan] == r_own);
  assign scan_last = (scan == THR_W'(NUM_THREADS - 1));
  assign out_free = !out_valid || out_ready;

  assign dp_status.out_free = out_free;
  assign dp_status.exit_ok = r_ok && (r_cmd == CMD_EXIT);
  assign dp_status.scan_done = scan_hit || scan_last;

  always_comb begin
    load = 1'b0;
    result = '0;
    if (cmd.exec) begin
      if (!r_ok) begin
        load = 1'b1;
        result.status = (r_cmd == CMD_ENTER) ? ST_BAD_ENTER : ST_BAD_EXIT;
      end else if (r_cmd == CMD_ENTER) begin
        load = 1'b1;
        result.status = prev_busy ? ST_QUEUED : ST_GRANTED;
      end
    end else if (cmd.scan) begin
      if (scan_hit) begin
        load = 1'b1;
        result.status = ST_RELEASED;
        result.handoff_valid = 1'b1;
        result.handoff_thread = TID_W'(scan);
      end else if (scan_last) begin
        load = 1'b1;
        result.status = ST_RELEASED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < NUM_THREADS; t++) begin
        own_cell[t] <= CELL_W'(t + 1);
        pred_cell[t] <= CELL_W'(t + 1);
        thread_mode[t] <= MODE_IDLE;
      end
      for (int c = 0; c <= NUM_THREADS; c++) begin
        cell_flag[c] <= 1'b0;
      end
      tail_cell <= '0;
      active_threads <= ACTIVE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        active_threads <= cfg_wdata;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.exec && r_ok) begin
        if (r_cmd == CMD_ENTER) begin
          cell_flag[r_own] <= 1'b1;
          pred_cell[tidx] <= tail_cell;
          tail_cell <= r_own;
          thread_mode[tidx] <= prev_busy ? MODE_WAITING : MODE_HOLDING;
        end else begin
          cell_flag[r_own] <= 1'b0;
          own_cell[tidx] <= r_pred;
          thread_mode[tidx] <= MODE_IDLE;
        end
      end
      if (cmd.scan && scan_hit) begin
        thread_mode[scan] <= MODE_HOLDING;
      end
    end
  end

  // request latch, lookup registers, the scan pointer and the output data register
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      r_cmd <= in_data.command;
      r_tid <= in_data.thread_id;
    end
    if (cmd.fetch) begin
      r_own <= own_cell[tidx];
      r_pred <= pred_cell[tidx];
      r_ok <= in_range && ((r_cmd == CMD_ENTER) ? (thread_mode[tidx] == MODE_IDLE)
                                                : (thread_mode[tidx] == MODE_HOLDING));
    end
    if (cmd.exec) begin
      scan <= '0;
    end else if (cmd.scan && !scan_hit && !scan_last) begin
      scan <= scan + 1'b1;
    end
    if (load) begin
      out_data <= result;
    end
  end

endmodule
`default_nettype wire

[rtl/core/clh_checker.sv]
`default_nettype none
module clh_checker (
  input wire                      clk,
  input wire                      rst,
  input wire                      in_valid,
  input wire                      in_ready,
  input wire                      out_valid,
  input wire                      out_ready,
  input clh_pkg::out_item_t       out_data
);
  import clh_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one item at a time: after an accept the input side closes
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while busy");

  // a handoff only comes with a release
  a_handoff_release: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.handoff_valid |-> out_data.status == ST_RELEASED)
    else $error("handoff without release");

  a_no_handoff_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.handoff_valid |-> out_data.handoff_thread == '0)
    else $error("handoff thread set without handoff");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status <= ST_BAD_EXIT)
    else $error("undefined status code");

endmodule

bind clh_queue_lock_unit clh_checker u_clh_checker (.*);
`default_nettype wire
